>>> sv/bums_pkg.sv
// shared constants, types and state codes of the bottom-up merge sorter
package bums_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned SUM_W      = CNT_W + 1;

  typedef logic        [IDX_W-1:0]      idx_t;
  typedef logic        [CNT_W-1:0]      cnt_t;
  typedef logic        [SUM_W-1:0]      sum_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // request from the sequencer to the two ping-pong stores
  typedef struct packed {
    logic  wr_en;
    logic  wr_sel;
    idx_t  wr_addr;
    data_t wr_data;
    idx_t  rd_addr_a;
    idx_t  rd_addr_b;
    logic  rd_sel;
  } store_req_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

endpackage

>>> sv/bums_if.sv
// valid/ready stream interfaces for the input and result channels
interface bums_in_if;
  logic          valid;
  logic          ready;
  bums_pkg::data_t value_in;
  logic          is_last_in;

  modport source (output valid, output value_in, output is_last_in, input ready);
  modport sink   (input valid, input value_in, input is_last_in, output ready);
endinterface

interface bums_out_if;
  logic          valid;
  logic          ready;
  bums_pkg::data_t value_out;
  logic          is_last_out;
  logic          overflowed;

  modport source (output valid, output value_out, output is_last_out, output overflowed,
                  input ready);
  modport sink   (input valid, input value_out, input is_last_out, input overflowed,
                  output ready);
endinterface

>>> sv/bums_store.sv
// two ping-pong value memories, one write port and two registered read ports each
module bums_store (
  input  logic                clk_i,
  input  bums_pkg::store_req_t req_i,
  output bums_pkg::data_t     rd_a_o,
  output bums_pkg::data_t     rd_b_o
);
  import bums_pkg::*;

  data_t mem0 [DEPTH];
  data_t mem1 [DEPTH];
  data_t m0_a_q, m0_b_q, m1_a_q, m1_b_q;
  logic  sel_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && !req_i.wr_sel) begin
      mem0[req_i.wr_addr] <= req_i.wr_data;
    end
    m0_a_q <= mem0[req_i.rd_addr_a];
    m0_b_q <= mem0[req_i.rd_addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && req_i.wr_sel) begin
      mem1[req_i.wr_addr] <= req_i.wr_data;
    end
    m1_a_q <= mem1[req_i.rd_addr_a];
    m1_b_q <= mem1[req_i.rd_addr_b];
    sel_q  <= req_i.rd_sel;
  end

  assign rd_a_o = sel_q ? m1_a_q : m0_a_q;
  assign rd_b_o = sel_q ? m1_b_q : m0_b_q;

endmodule

>>> sv/bums_merge_unit.sv
// shared compare and select unit: picks the next element of a two-run merge
module bums_merge_unit (
  input  bums_pkg::data_t head_a_i,
  input  bums_pkg::data_t head_b_i,
  input  bums_pkg::cnt_t  a_i,
  input  bums_pkg::cnt_t  b_i,
  input  bums_pkg::cnt_t  mid_i,
  input  bums_pkg::cnt_t  hi_i,
  output logic            take_a_o,
  output bums_pkg::data_t value_o
);
  import bums_pkg::*;

  logic a_left, b_left;

  assign a_left = a_i < mid_i;
  assign b_left = b_i < hi_i;

  // ties go to the right-hand run
  assign take_a_o = a_left && (!b_left || (head_a_i < head_b_i));
  assign value_o  = take_a_o ? head_a_i : head_b_i;

endmodule

>>> sv/bottom_up_merge_sorter_core.sv
// top level of the bottom-up merge sorter: load, merge sequencer and result register
//
// in_i  : one signed value per transfer; is_last_in closes the set and starts the sort.
//         ready is high only while the block is loading.
// out_o : the sorted set, ascending, one value per transfer; is_last_out marks the final
//         value, overflowed is set on every value of a set that lost values beyond DEPTH.
// a set of n values is merged in passes of run width 1, 2, 4, ... until one run covers
// the set; each pass runs through the single compare unit, which reads two heads from
// one memory and writes the chosen value into the other (ping-pong).
// a set of n values takes n load transfers, the merge passes and n result transfers.
// results pass through one output register: a stalled receiver holds the emit, and the
// block takes the next set's values as soon as the last result is in the register.
// reset empties the set and the result register; memory contents need no clearing,
// only written entries are ever read.
module bottom_up_merge_sorter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bums_in_if.sink      in_i,
  bums_out_if.source   out_o
);
  import bums_pkg::*;

  state_e     state_q, state_d;
  cnt_t       count_q, count_d;
  logic       ovf_q, ovf_d;
  cnt_t       w_q, w_d;
  logic       src_q, src_d;
  cnt_t       a_q, a_d;
  cnt_t       b_q, b_d;
  cnt_t       k_q, k_d;
  cnt_t       mid_q, mid_d;
  cnt_t       hi_q, hi_d;

  logic       ov_q, ov_d;
  data_t      out_val_q, out_val_d;
  logic       out_last_q, out_last_d;
  logic       out_ovf_q, out_ovf_d;

  store_req_t req;
  data_t      head_a, head_b;
  logic       take_a;
  data_t      sel_value;

  logic       in_fire, out_fire, out_load;
  cnt_t       base;
  sum_t       mid_s, hi_s, n_s;
  cnt_t       mid_n, hi_n;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // bounds of the next run pair: starts at zero on a new pass, else after the last pair
  assign base  = (state_q == ST_MERGE) ? hi_q : '0;
  assign mid_s = {1'b0, base} + {1'b0, w_q};
  assign hi_s  = {1'b0, base} + {w_q, 1'b0};
  assign n_s   = {1'b0, count_q};
  assign mid_n = (mid_s > n_s) ? count_q : mid_s[CNT_W-1:0];
  assign hi_n  = (hi_s > n_s) ? count_q : hi_s[CNT_W-1:0];

  bums_merge_unit u_merge (
    .head_a_i (head_a),
    .head_b_i (head_b),
    .a_i      (a_q),
    .b_i      (b_q),
    .mid_i    (mid_q),
    .hi_i     (hi_q),
    .take_a_o (take_a),
    .value_o  (sel_value)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    w_d        = w_q;
    src_d      = src_q;
    a_d        = a_q;
    b_d        = b_q;
    k_d        = k_q;
    mid_d      = mid_q;
    hi_d       = hi_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    out_load   = 1'b0;

    req.wr_en   = 1'b0;
    req.wr_sel  = 1'b0;
    req.wr_addr = count_q[IDX_W-1:0];
    req.wr_data = in_i.value_in;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          // values beyond the store depth are dropped and remembered
          if (count_q < cnt_t'(DEPTH)) begin
            req.wr_en = 1'b1;
            count_d   = count_q + cnt_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.is_last_in) begin
            state_d = ST_SETUP;
            w_d     = cnt_t'(1);
            src_d   = 1'b0;
          end
        end
      end

      ST_SETUP: begin
        // also the gap that lets the last write of a pass settle
        if (w_q >= count_q) begin
          state_d = ST_EMIT;
          a_d     = '0;
        end else begin
          state_d = ST_MERGE;
          a_d     = '0;
          b_d     = mid_n;
          k_d     = '0;
          mid_d   = mid_n;
          hi_d    = hi_n;
        end
      end

      ST_MERGE: begin
        req.wr_en   = 1'b1;
        req.wr_sel  = ~src_q;
        req.wr_addr = k_q[IDX_W-1:0];
        req.wr_data = sel_value;
        a_d = take_a ? a_q + cnt_t'(1) : a_q;
        b_d = take_a ? b_q : b_q + cnt_t'(1);
        k_d = k_q + cnt_t'(1);
        if (k_d == hi_q) begin
          if (hi_q == count_q) begin
            // pass done: width doubles, the written memory becomes the source
            state_d = ST_SETUP;
            w_d     = {w_q[CNT_W-2:0], 1'b0};
            src_d   = ~src_q;
          end else begin
            a_d   = hi_q;
            b_d   = mid_n;
            k_d   = hi_q;
            mid_d = mid_n;
            hi_d  = hi_n;
          end
        end
      end

      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          out_load   = 1'b1;
          out_val_d  = head_a;
          out_last_d = (a_q + cnt_t'(1)) == count_q;
          out_ovf_d  = ovf_q;
          a_d        = a_q + cnt_t'(1);
          if (out_last_d) begin
            state_d = ST_LOAD;
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // reads always target the next pointers, so the heads line up with a_q and b_q
    req.rd_addr_a = a_d[IDX_W-1:0];
    req.rd_addr_b = b_d[IDX_W-1:0];
    req.rd_sel    = src_d;
  end

  always_comb begin
    priority if (out_load) begin
      ov_d = 1'b1;
    end else if (out_fire) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  bums_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_a_o (head_a),
    .rd_b_o (head_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      w_q     <= '0;
      src_q   <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      w_q     <= w_d;
      src_q   <= src_d;
      a_q     <= a_d;
      b_q     <= b_d;
      k_q     <= k_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      ov_q    <= ov_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.value_out   = out_val_q;
  assign out_o.is_last_out = out_last_q;
  assign out_o.overflowed  = out_ovf_q;

endmodule
